### rtl/npc_pkg.sv
// ---------------------------------------------------------------------------
// npc_pkg
// Shared types and constants of the nearest palette color blend block.
// ---------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

   localparam int PALETTE_DEPTH_DEF = 256;
   localparam int MAX_ENTRIES       = 256;

   localparam int CHAN_W   = 8;
   localparam int INDEX_W  = 8;
   localparam int DIST_W   = 10;
   localparam int CFG_W    = 9;
   localparam int CSR_IDX_W = 1;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_PIXEL = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_PALETTE_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_BLEND_WEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] WEIGHT_FULL = 9'd256;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } color_type;

   typedef struct packed {
      logic               action;
      logic [INDEX_W-1:0] slot;
      color_type          pixel;
      logic [INDEX_W-1:0] best_index;
      logic [DIST_W-1:0]  best_dist;
      color_type          best_color;
   } beat_type;

   function automatic logic [DIST_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      logic [CHAN_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return {{(DIST_W-CHAN_W){1'b0}}, d};
   endfunction

endpackage

`default_nettype wire

### rtl/nearest_palette_color_blend.sv
// ---------------------------------------------------------------------------
// nearest_palette_color_blend
// Nearest palette color search by L1 distance with blend toward the match.
//
// A beat is taken on start while busy is low; busy is always low, so one
// beat can enter every cycle. A beat with action 0 writes a palette entry;
// a beat with action 1 is a pixel. Both travel down a chain of one registered
// cell per palette entry, so writes and pixels stay in order.
// Each cell holds one entry and updates the pixel's running best match.
// After the chain a two-stage blend produces the result.
// A pixel passes through the NUM_CELLS cells, NUM_CELLS = min(PALETTE_DEPTH,
// 256), and then through both blend stages before its rsp_valid strobe.
// Throughput: one beat per cycle, the chain depth sets only the latency.
// A palette write gives no result; the cell whose index equals its slot
// stores its color.
// Results are shown for one cycle on rsp_valid; the receiver cannot stall.
// Reset clears the pipeline and sets palette_size to 1 and blend_weight to
// 256; palette entries are undefined until written. Registers are written
// through csr_write with csr_index selecting the register.
// ---------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_blend #(
   parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_action,
   input  wire logic [npc_pkg::INDEX_W-1:0]   req_entry_index,
   input  wire logic [npc_pkg::CHAN_W-1:0]    req_red_in,
   input  wire logic [npc_pkg::CHAN_W-1:0]    req_green_in,
   input  wire logic [npc_pkg::CHAN_W-1:0]    req_blue_in,
   output logic                               rsp_valid,
   output logic [npc_pkg::CHAN_W-1:0]         rsp_red_out,
   output logic [npc_pkg::CHAN_W-1:0]         rsp_green_out,
   output logic [npc_pkg::CHAN_W-1:0]         rsp_blue_out,
   output logic [npc_pkg::INDEX_W-1:0]        rsp_match_index,
   output logic [npc_pkg::DIST_W-1:0]         rsp_match_distance,
   input  wire logic                          csr_write,
   input  wire logic [npc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [npc_pkg::CFG_W-1:0]     csr_wdata
);
   import npc_pkg::*;

   localparam int NUM_CELLS = (PALETTE_DEPTH < MAX_ENTRIES) ? PALETTE_DEPTH : MAX_ENTRIES;
   localparam logic [CFG_W-1:0] SIZE_LIMIT = CFG_W'(NUM_CELLS);

   logic [CFG_W-1:0] size_ff;
   logic [CFG_W-1:0] size_in;
   logic [CFG_W-1:0] weight_ff;
   logic [CFG_W-1:0] weight_in;

   logic             chain_valid [NUM_CELLS+1];
   beat_type         chain_beat  [NUM_CELLS+1];

   assign busy = 1'b0;

   always_comb begin
      size_in   = size_ff;
      weight_in = weight_ff;
      if (csr_write) begin
         case (csr_index)
            REG_PALETTE_SIZE: begin
               if (csr_wdata == '0) begin
                  size_in = CFG_W'(1);
               end else if (csr_wdata > SIZE_LIMIT) begin
                  size_in = SIZE_LIMIT;
               end else begin
                  size_in = csr_wdata;
               end
            end
            REG_BLEND_WEIGHT: begin
               weight_in = (csr_wdata > WEIGHT_FULL) ? WEIGHT_FULL : csr_wdata;
            end
            default: begin
               size_in = size_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= CFG_W'(1);
         weight_ff <= WEIGHT_FULL;
      end else begin
         size_ff   <= size_in;
         weight_ff <= weight_in;
      end
   end

   always_comb begin
      chain_valid[0]                = start && !busy;
      chain_beat[0].action          = req_action;
      chain_beat[0].slot            = req_entry_index;
      chain_beat[0].pixel.red       = req_red_in;
      chain_beat[0].pixel.green     = req_green_in;
      chain_beat[0].pixel.blue      = req_blue_in;
      chain_beat[0].best_index      = '0;
      chain_beat[0].best_dist       = '1;
      chain_beat[0].best_color      = '0;
   end

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      npc_cell #(
         .CELL_INDEX (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .size_limit (size_ff),
         .valid_i    (chain_valid[k]),
         .beat_i     (chain_beat[k]),
         .valid_o    (chain_valid[k+1]),
         .beat_o     (chain_beat[k+1])
      );
   end

   npc_blend u_blend (
      .clock              (clock),
      .reset              (reset),
      .weight             (weight_ff),
      .valid_i            (chain_valid[NUM_CELLS]),
      .beat_i             (chain_beat[NUM_CELLS]),
      .rsp_valid          (rsp_valid),
      .rsp_red_out        (rsp_red_out),
      .rsp_green_out      (rsp_green_out),
      .rsp_blue_out       (rsp_blue_out),
      .rsp_match_index    (rsp_match_index),
      .rsp_match_distance (rsp_match_distance)
   );

endmodule

`default_nettype wire

### rtl/npc_cell.sv
// ---------------------------------------------------------------------------
// npc_cell
// One palette entry of the search chain: stores its color on a matching
// write beat and updates the running best match of each pixel beat.
// ---------------------------------------------------------------------------
`default_nettype none

module npc_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [npc_pkg::CFG_W-1:0]  size_limit,
   input  wire logic                       valid_i,
   input  wire npc_pkg::beat_type          beat_i,
   output logic                            valid_o,
   output npc_pkg::beat_type               beat_o
);
   import npc_pkg::*;

   color_type         color_ff;
   logic              valid_ff;
   beat_type          beat_ff;
   beat_type          beat_in;
   logic [DIST_W-1:0] cand_dist;
   logic              is_write;
   logic              active;
   logic              take;

   assign is_write  = valid_i && (beat_i.action == ACT_WRITE)
                      && (beat_i.slot == INDEX_W'(CELL_INDEX));
   assign active    = (CFG_W'(CELL_INDEX) < size_limit);
   assign cand_dist = abs_diff(beat_i.pixel.red,   color_ff.red)
                    + abs_diff(beat_i.pixel.green, color_ff.green)
                    + abs_diff(beat_i.pixel.blue,  color_ff.blue);
   assign take      = (CELL_INDEX == 0) || (active && (cand_dist < beat_i.best_dist));

   always_comb begin
      beat_in = beat_i;
      if (take) begin
         beat_in.best_index = INDEX_W'(CELL_INDEX);
         beat_in.best_dist  = cand_dist;
         beat_in.best_color = color_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (is_write) begin
         color_ff <= beat_i.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign valid_o = valid_ff;
   assign beat_o  = beat_ff;

endmodule

`default_nettype wire

### rtl/npc_blend.sv
// ---------------------------------------------------------------------------
// npc_blend
// Two-stage blend of the pixel toward its best match at the end of the
// chain, and the result strobe.
// ---------------------------------------------------------------------------
`default_nettype none

module npc_blend (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [npc_pkg::CFG_W-1:0]    weight,
   input  wire logic                         valid_i,
   input  wire npc_pkg::beat_type            beat_i,
   output logic                              rsp_valid,
   output logic [npc_pkg::CHAN_W-1:0]        rsp_red_out,
   output logic [npc_pkg::CHAN_W-1:0]        rsp_green_out,
   output logic [npc_pkg::CHAN_W-1:0]        rsp_blue_out,
   output logic [npc_pkg::INDEX_W-1:0]       rsp_match_index,
   output logic [npc_pkg::DIST_W-1:0]        rsp_match_distance
);
   import npc_pkg::*;

   localparam int DIFF_W = CHAN_W + 1;
   localparam int WGT_W  = CFG_W + 1;
   localparam int PROD_W = DIFF_W + WGT_W;
   localparam int SUM_W  = CHAN_W + 3;

   logic                    mul_valid_ff;
   logic                    mul_valid_in;
   logic signed [PROD_W-1:0] prod_ff [3];
   logic signed [PROD_W-1:0] prod_in [3];
   color_type               pixel_ff;
   logic [INDEX_W-1:0]      index_ff;
   logic [DIST_W-1:0]       dist_ff;

   logic                    out_valid_ff;
   color_type               out_color_ff;
   color_type               out_color_in;
   logic [INDEX_W-1:0]      out_index_ff;
   logic [DIST_W-1:0]       out_dist_ff;

   logic [CHAN_W-1:0]       pix_ch [3];
   logic [CHAN_W-1:0]       best_ch [3];
   logic [CHAN_W-1:0]       held_ch [3];
   logic [CHAN_W-1:0]       res_ch [3];
   logic signed [DIFF_W-1:0] diff [3];
   logic signed [WGT_W-1:0] wgt;
   logic signed [PROD_W-1:0] shifted [3];
   logic [SUM_W-1:0]        sum [3];

   assign mul_valid_in = valid_i && (beat_i.action == ACT_PIXEL);
   assign wgt          = signed'({1'b0, weight});

   assign pix_ch[0]  = beat_i.pixel.red;
   assign pix_ch[1]  = beat_i.pixel.green;
   assign pix_ch[2]  = beat_i.pixel.blue;
   assign best_ch[0] = beat_i.best_color.red;
   assign best_ch[1] = beat_i.best_color.green;
   assign best_ch[2] = beat_i.best_color.blue;
   assign held_ch[0] = pixel_ff.red;
   assign held_ch[1] = pixel_ff.green;
   assign held_ch[2] = pixel_ff.blue;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k]    = signed'({1'b0, best_ch[k]}) - signed'({1'b0, pix_ch[k]});
         prod_in[k] = PROD_W'(diff[k]) * PROD_W'(wgt);
         shifted[k] = prod_ff[k] >>> CHAN_W;
         sum[k]     = {{(SUM_W-CHAN_W){1'b0}}, held_ch[k]} + shifted[k][SUM_W-1:0];
         res_ch[k]  = sum[k][CHAN_W-1:0];
      end
      out_color_in.red   = res_ch[0];
      out_color_in.green = res_ch[1];
      out_color_in.blue  = res_ch[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         out_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      pixel_ff     <= beat_i.pixel;
      index_ff     <= beat_i.best_index;
      dist_ff      <= beat_i.best_dist;
      out_color_ff <= out_color_in;
      out_index_ff <= index_ff;
      out_dist_ff  <= dist_ff;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_red_out        = out_color_ff.red;
   assign rsp_green_out      = out_color_ff.green;
   assign rsp_blue_out       = out_color_ff.blue;
   assign rsp_match_index    = out_index_ff;
   assign rsp_match_distance = out_dist_ff;

endmodule

`default_nettype wire
